### src/mtd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared types, constants and helper functions for the meter telegram
// deframer: phase codes, event codes, item/result structs, CRC and hex decode.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int MAX_LEN  = 2048;
    localparam int LEN_W    = 11;
    localparam int MS_W     = 16;
    localparam int CFG_W    = 15;
    localparam int CRC_W    = 16;
    localparam int CNT_W    = 32;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 2);

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] CHAR_START = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_END   = 8'h21;  // '!'

    localparam logic [CFG_W-1:0] RX_TIMEOUT_RESET  = CFG_W'(5000);
    localparam logic [CFG_W-1:0] CRC_TIMEOUT_RESET = CFG_W'(1000);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_RX_TIMEOUT  = 1'b0;
    localparam logic REG_CRC_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_CRC  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_DONE        = 3'd0,
        EV_CRC_TIMEOUT = 3'd1,
        EV_OVERFLOW    = 3'd2,
        EV_RX_TIMEOUT  = 3'd3,
        EV_DISCONNECT  = 3'd4
    } event_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        event_t           event_res;
        logic             crc_ok;
        logic [LEN_W-1:0] telegram_length;
        logic [CRC_W-1:0] received_crc;
        logic [CRC_W-1:0] computed_crc;
        logic [CNT_W-1:0] telegram_number;
        logic             meter_connected;
        logic [CNT_W-1:0] bytes_seen;
    } result_t;

    // CRC-16, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // returns {bad, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = {1'b1, 4'h0};
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b0, 4'(ch - 8'h30)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b0, 4'(ch - 8'h41 + 8'd10)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b0, 4'(ch - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/mtd_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_in_reg
// Input register: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module mtd_in_reg
    import mtd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

### src/mtd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_core
// Framing state, CRC, checksum parse, timeouts and counters; one beat per step.
// ----------------------------------------------------------------------------
module mtd_core
    import mtd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             step,
    input  wire item_t            item,
    output logic                  res_fire,
    output result_t               res
);

    logic [CFG_W-1:0] rto_reg, cto_reg;

    phase_t           phase_reg, phase_next;
    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [CRC_W-1:0] parsed_reg, parsed_next;
    logic             hex_err_reg, hex_err_next;
    logic [2:0]       taken_reg, taken_next;
    logic [MS_W-1:0]  ms_byte_reg, ms_byte_next;
    logic [MS_W-1:0]  ms_end_reg, ms_end_next;
    logic             seen_reg, seen_next;
    logic             conn_reg, conn_next;
    logic [CNT_W-1:0] tel_cnt_reg, tel_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;

    logic             is_byte, is_slash, is_end;
    logic [LEN_W-1:0] cnt_inc;
    logic [2:0]       taken_inc;
    logic [4:0]       hex;
    logic [CRC_W-1:0] crc_body, crc_slash;
    logic [MS_W-1:0]  ms_byte_inc, ms_end_inc;
    logic             crc_last, body_full, end_full;
    logic             crc_to_hit, rx_to_hit, disc_hit;

    assign is_byte   = (item.command == CMD_BYTE);
    assign is_slash  = (item.data_byte == CHAR_START);
    assign is_end    = (item.data_byte == CHAR_END);
    assign cnt_inc   = count_reg + LEN_W'(1);
    assign taken_inc = taken_reg + 3'd1;
    assign hex       = hex_decode(item.data_byte);
    assign crc_body  = crc_feed(crc_reg, item.data_byte);
    assign crc_slash = crc_feed('0, CHAR_START);

    assign ms_byte_inc = (ms_byte_reg != '1) ? ms_byte_reg + MS_W'(1) : ms_byte_reg;
    assign ms_end_inc  = (ms_end_reg != '1) ? ms_end_reg + MS_W'(1) : ms_end_reg;

    assign crc_last   = (taken_inc >= 3'd4) || (cnt_inc >= LEN_LIMIT);
    assign body_full  = (count_reg >= LEN_LIMIT);
    assign end_full   = (cnt_inc >= LEN_LIMIT);
    assign crc_to_hit = (ms_end_inc >= {1'b0, cto_reg});
    assign rx_to_hit  = seen_reg && (ms_byte_inc > {1'b0, rto_reg});
    assign disc_hit   = conn_reg && seen_reg && (ms_byte_inc > {rto_reg, 1'b0});

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rto_reg <= RX_TIMEOUT_RESET;
            cto_reg <= CRC_TIMEOUT_RESET;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_RX_TIMEOUT:  rto_reg <= cfg_data;
                REG_CRC_TIMEOUT: cto_reg <= cfg_data;
                default:         rto_reg <= rto_reg;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            if (is_byte) begin
                unique case (phase_reg)
                    PH_CRC:  phase_next = crc_last ? PH_IDLE : PH_CRC;
                    PH_BODY: begin
                        if (is_slash) begin
                            phase_next = PH_BODY;
                        end else if (body_full) begin
                            phase_next = PH_IDLE;
                        end else if (is_end) begin
                            phase_next = end_full ? PH_IDLE : PH_CRC;
                        end
                    end
                    PH_IDLE: phase_next = is_slash ? PH_BODY : PH_IDLE;
                    default: phase_next = PH_IDLE;
                endcase
            end else begin
                unique case (phase_reg)
                    PH_CRC:  phase_next = crc_to_hit ? PH_IDLE : PH_CRC;
                    PH_BODY: phase_next = rx_to_hit ? PH_IDLE : PH_BODY;
                    PH_IDLE: phase_next = PH_IDLE;
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        crc_next      = crc_reg;
        count_next    = count_reg;
        parsed_next   = parsed_reg;
        hex_err_next  = hex_err_reg;
        taken_next    = taken_reg;
        ms_byte_next  = ms_byte_reg;
        ms_end_next   = ms_end_reg;
        seen_next     = seen_reg;
        conn_next     = conn_reg;
        tel_cnt_next  = tel_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        res_fire      = 1'b0;
        res           = '0;
        res.event_res = EV_DONE;

        if (step) begin
            if (is_byte) begin
                byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                ms_byte_next  = '0;
                seen_next     = 1'b1;
                if (phase_reg == PH_CRC) begin
                    hex_err_next = hex_err_reg | hex[4];
                    parsed_next  = {parsed_reg[CRC_W-5:0], hex[3:0]};
                    taken_next   = taken_inc;
                    count_next   = cnt_inc;
                    if (crc_last) begin
                        res_fire   = 1'b1;
                        count_next = '0;
                    end
                end else if (is_slash) begin
                    crc_next   = crc_slash;
                    count_next = LEN_W'(1);
                    conn_next  = 1'b1;
                end else if (phase_reg == PH_BODY) begin
                    if (!body_full) begin
                        count_next = cnt_inc;
                        crc_next   = crc_body;
                        if (is_end) begin
                            parsed_next  = '0;
                            hex_err_next = 1'b0;
                            taken_next   = '0;
                            ms_end_next  = '0;
                            if (end_full) begin
                                res_fire   = 1'b1;
                                count_next = '0;
                            end
                        end
                    end else begin
                        // buffer full: abort the telegram
                        conn_next           = 1'b0;
                        count_next          = '0;
                        res_fire            = 1'b1;
                        res.event_res       = EV_OVERFLOW;
                        res.telegram_length = count_reg;
                    end
                end
                if (res_fire && res.event_res == EV_DONE) begin
                    tel_cnt_next        = tel_cnt_reg + CNT_W'(1);
                    res.crc_ok          = !hex_err_next && (taken_next == 3'd4) &&
                                          (parsed_next == crc_next);
                    res.telegram_length = cnt_inc;
                    res.received_crc    = parsed_next;
                    res.computed_crc    = crc_next;
                end
            end else begin
                ms_byte_next = ms_byte_inc;
                unique case (phase_reg)
                    PH_CRC: begin
                        ms_end_next = ms_end_inc;
                        if (crc_to_hit) begin
                            res_fire            = 1'b1;
                            res.event_res       = EV_CRC_TIMEOUT;
                            res.telegram_length = count_reg;
                            count_next          = '0;
                        end
                    end
                    PH_BODY: begin
                        if (rx_to_hit) begin
                            conn_next           = 1'b0;
                            seen_next           = 1'b0;
                            res_fire            = 1'b1;
                            res.event_res       = EV_RX_TIMEOUT;
                            res.telegram_length = count_reg;
                            count_next          = '0;
                        end
                    end
                    default: begin
                        if (disc_hit) begin
                            conn_next     = 1'b0;
                            seen_next     = 1'b0;
                            res_fire      = 1'b1;
                            res.event_res = EV_DISCONNECT;
                        end
                    end
                endcase
            end
            res.telegram_number = tel_cnt_next;
            res.meter_connected = conn_next;
            res.bytes_seen      = byte_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            crc_reg      <= '0;
            count_reg    <= '0;
            parsed_reg   <= '0;
            hex_err_reg  <= 1'b0;
            taken_reg    <= '0;
            ms_byte_reg  <= '0;
            ms_end_reg   <= '0;
            seen_reg     <= 1'b0;
            conn_reg     <= 1'b0;
            tel_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
            parsed_reg   <= parsed_next;
            hex_err_reg  <= hex_err_next;
            taken_reg    <= taken_next;
            ms_byte_reg  <= ms_byte_next;
            ms_end_reg   <= ms_end_next;
            seen_reg     <= seen_next;
            conn_reg     <= conn_next;
            tel_cnt_reg  <= tel_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

endmodule
`default_nettype wire

### src/mtd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mtd_out_reg
    import mtd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire logic    res_fire,
    input  wire result_t res,
    output logic         out_free,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    // load only happens while the slot is free, so a silent step empties it
    assign valid_next = load ? res_fire : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_fire) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule
`default_nettype wire

### src/meter_telegram_deframer_crc16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meter_telegram_deframer_crc16
// Serial telegram deframer: start/end markers, CRC-16 check of the hex
// checksum, CRC and receive timeouts, disconnect detection and counters.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_command, s_data_byte
// m_       out  m_valid/m_ready    event, crc, length, counters, connected flag
// cfg_     in   cfg_write_en       cfg_index, cfg_data (no read-back)
//
// One beat per clock unless m_ready stalls: the input register feeds the core,
// which updates all state and loads the result register in the same cycle.
// A beat advances only while the result register is empty or being drained,
// so an m_ready stall backs up into s_ready. Synchronous active-low reset
// restores the default timeouts and clears all framing state and counters.
// ----------------------------------------------------------------------------
module meter_telegram_deframer_crc16
    import mtd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_command,
    input  wire logic [7:0]       s_data_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_event_res,
    output logic                  m_crc_ok,
    output logic [LEN_W-1:0]      m_telegram_length,
    output logic [CRC_W-1:0]      m_received_crc,
    output logic [CRC_W-1:0]      m_computed_crc,
    output logic [CNT_W-1:0]      m_telegram_number,
    output logic                  m_meter_connected,
    output logic [CNT_W-1:0]      m_bytes_seen
);

    item_t   s_item, item;
    logic    item_valid, advance, out_free, res_fire;
    result_t res, m_res;

    assign s_item.command   = s_command;
    assign s_item.data_byte = s_data_byte;
    assign advance          = item_valid && out_free;

    mtd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mtd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (advance),
        .item         (item),
        .res_fire     (res_fire),
        .res          (res)
    );

    mtd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res_fire (res_fire),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_event_res       = m_res.event_res;
    assign m_crc_ok          = m_res.crc_ok;
    assign m_telegram_length = m_res.telegram_length;
    assign m_received_crc    = m_res.received_crc;
    assign m_computed_crc    = m_res.computed_crc;
    assign m_telegram_number = m_res.telegram_number;
    assign m_meter_connected = m_res.meter_connected;
    assign m_bytes_seen      = m_res.bytes_seen;

endmodule
`default_nettype wire

### sim/tb_meter_telegram_deframer_crc16.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_meter_telegram_deframer_crc16
// Self-checking bench for the meter telegram deframer. Drives serial bytes
// and millisecond ticks with random gaps, stalls the result channel, and
// checks every event against an in-bench telegram tracker. Timeout settings
// are changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_meter_telegram_deframer_crc16;
    import mtd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        CS_UPPER,
        CS_LOWER,
        CS_MIXED,
        CS_FLIP,
        CS_BAD_CHAR,
        CS_SLASH,
        CS_SHORT
    } csum_mode_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             cfg_write_en = 1'b0;
    logic             cfg_index    = REG_RX_TIMEOUT;
    logic [CFG_W-1:0] cfg_data     = '0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic             s_command    = CMD_BYTE;
    logic [7:0]       s_data_byte  = 8'h00;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [2:0]       m_event_res;
    logic             m_crc_ok;
    logic [LEN_W-1:0] m_telegram_length;
    logic [CRC_W-1:0] m_received_crc;
    logic [CRC_W-1:0] m_computed_crc;
    logic [CNT_W-1:0] m_telegram_number;
    logic             m_meter_connected;
    logic [CNT_W-1:0] m_bytes_seen;

    meter_telegram_deframer_crc16 u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Tracks framing state, timeouts and counters; holds the events still due
    class telegram_tracker;
        phase_t           stage;
        logic [15:0]      crc_acc;
        int unsigned      held;
        logic [15:0]      rx_crc;
        bit               bad_hex;
        int unsigned      crc_chars;
        int unsigned      idle_ms;
        int unsigned      end_ms;
        bit               heard;
        bit               connected;
        logic [CNT_W-1:0] n_telegrams;
        logic [CNT_W-1:0] n_bytes;
        int unsigned      rx_timeout;
        int unsigned      csum_limit_ms;
        result_t          due[$];
        int unsigned      errors;
        int unsigned      beats;
        int unsigned      per_event[5];

        function new();
            stage         = PH_IDLE;
            crc_acc       = '0;
            held          = 0;
            rx_crc        = '0;
            bad_hex       = 1'b0;
            crc_chars     = 0;
            idle_ms       = 0;
            end_ms        = 0;
            heard         = 1'b0;
            connected     = 1'b0;
            n_telegrams   = '0;
            n_bytes       = '0;
            rx_timeout    = RX_TIMEOUT_RESET;
            csum_limit_ms = CRC_TIMEOUT_RESET;
            errors        = 0;
            beats         = 0;
            foreach (per_event[i]) per_event[i] = 0;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            int k;
            c = crc ^ {b, 8'h00};
            for (k = 0; k < 8; k++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
            end
            return c;
        endfunction

        function void set_timeouts(logic [CFG_W-1:0] rx, logic [CFG_W-1:0] crc);
            rx_timeout    = rx;
            csum_limit_ms = crc;
        endfunction

        function void post(event_t ev, bit ok, int unsigned len, logic [15:0] rx,
                           logic [15:0] calc);
            result_t r;
            r.event_res       = ev;
            r.crc_ok          = ok;
            r.telegram_length = LEN_W'(len);
            r.received_crc    = rx;
            r.computed_crc    = calc;
            r.telegram_number = n_telegrams;
            r.meter_connected = connected;
            r.bytes_seen      = n_bytes;
            due.push_back(r);
        endfunction

        function void close_telegram();
            bit ok;
            ok = !bad_hex && crc_chars == 4 && rx_crc == crc_acc;
            n_telegrams = n_telegrams + 1;
            post(EV_DONE, ok, held, rx_crc, crc_acc);
            stage = PH_IDLE;
            held  = 0;
        endfunction

        function void take_beat(logic cmd, logic [7:0] b);
            logic [3:0] nib;
            beats++;
            if (cmd == CMD_BYTE) begin
                n_bytes = n_bytes + 1;
                idle_ms = 0;
                heard   = 1'b1;
                if (stage == PH_CRC) begin
                    // every byte after the end marker is a checksum character
                    nib = 4'h0;
                    if (b >= "0" && b <= "9") nib = 4'(b - "0");
                    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
                    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
                    else bad_hex = 1'b1;
                    rx_crc = {rx_crc[11:0], nib};
                    crc_chars++;
                    held++;
                    if (crc_chars >= 4 || held >= MAX_LEN - 2) close_telegram();
                    return;
                end
                if (b == CHAR_START) begin
                    stage     = PH_BODY;
                    crc_acc   = crc_step(16'h0000, b);
                    held      = 1;
                    connected = 1'b1;
                    return;
                end
                if (stage == PH_BODY) begin
                    if (held < MAX_LEN - 2) begin
                        held++;
                        crc_acc = crc_step(crc_acc, b);
                        if (b == CHAR_END) begin
                            stage     = PH_CRC;
                            rx_crc    = '0;
                            bad_hex   = 1'b0;
                            crc_chars = 0;
                            end_ms    = 0;
                            if (held >= MAX_LEN - 2) close_telegram();
                        end
                    end else begin
                        stage     = PH_IDLE;
                        connected = 1'b0;
                        post(EV_OVERFLOW, 1'b0, held, 16'h0, 16'h0);
                        held = 0;
                    end
                end
                return;
            end
            if (idle_ms < 16'hFFFF) idle_ms++;
            if (stage == PH_CRC) begin
                if (end_ms < 16'hFFFF) end_ms++;
                if (end_ms >= csum_limit_ms) begin
                    stage = PH_IDLE;
                    post(EV_CRC_TIMEOUT, 1'b0, held, 16'h0, 16'h0);
                    held = 0;
                end
            end else if (stage == PH_BODY) begin
                if (heard && idle_ms > rx_timeout) begin
                    stage     = PH_IDLE;
                    connected = 1'b0;
                    heard     = 1'b0;
                    post(EV_RX_TIMEOUT, 1'b0, held, 16'h0, 16'h0);
                    held = 0;
                end
            end else if (connected && heard && idle_ms > 2 * rx_timeout) begin
                connected = 1'b0;
                heard     = 1'b0;
                post(EV_DISCONNECT, 1'b0, 0, 16'h0, 16'h0);
            end
        endfunction

        task report(string what, longint unsigned want, longint unsigned seen);
            $display("ERROR %s: expected 0x%0h, got 0x%0h", what, want, seen);
            errors++;
        endtask

        task check_event(result_t got);
            result_t exp;
            if (got.event_res < 5) per_event[got.event_res]++;
            if (due.size() == 0) begin
                report("result with nothing pending, event", 0, got.event_res);
                return;
            end
            exp = due.pop_front();
            if (got.event_res != exp.event_res)
                report("event_res", exp.event_res, got.event_res);
            if (got.crc_ok != exp.crc_ok)
                report("crc_ok", exp.crc_ok, got.crc_ok);
            if (got.telegram_length != exp.telegram_length)
                report("telegram_length", exp.telegram_length, got.telegram_length);
            if (got.received_crc != exp.received_crc)
                report("received_crc", exp.received_crc, got.received_crc);
            if (got.computed_crc != exp.computed_crc)
                report("computed_crc", exp.computed_crc, got.computed_crc);
            if (got.telegram_number != exp.telegram_number)
                report("telegram_number", exp.telegram_number, got.telegram_number);
            if (got.meter_connected != exp.meter_connected)
                report("meter_connected", exp.meter_connected, got.meter_connected);
            if (got.bytes_seen != exp.bytes_seen)
                report("bytes_seen", exp.bytes_seen, got.bytes_seen);
        endtask
    endclass

    telegram_tracker tracker;
    bit              idle_on  = 1'b1;
    bit              counting = 1'b1;
    int unsigned     counted  = 0;
    int unsigned     cur_rx   = RX_TIMEOUT_RESET;
    int unsigned     cur_crc  = CRC_TIMEOUT_RESET;
    int unsigned     hold_left = 0;
    int unsigned     quiet     = 0;

    // Result side: random stall bursts
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            hold_left <= $urandom_range(1, 16) - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.event_res       = event_t'(m_event_res);
                got.crc_ok          = m_crc_ok;
                got.telegram_length = m_telegram_length;
                got.received_crc    = m_received_crc;
                got.computed_crc    = m_computed_crc;
                got.telegram_number = m_telegram_number;
                got.meter_connected = m_meter_connected;
                got.bytes_seen      = m_bytes_seen;
                tracker.check_event(got);
            end
            if (s_valid && s_ready) tracker.take_beat(s_command, s_data_byte);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_write_en) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(logic cmd, logic [7:0] b);
        if (idle_on && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counting) counted++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_beat(CMD_BYTE, b);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] hex_digit(logic [3:0] nib, bit lower);
        if (nib < 10) return 8'("0") + 8'(nib);
        return (lower ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
    endfunction

    // Start marker plus body bytes with no markers; returns the running CRC
    task automatic fill_frame(int body_len, bit with_ticks, output logic [15:0] crc);
        logic [7:0] b;
        int k;
        crc = telegram_tracker::crc_step(16'h0000, CHAR_START);
        send_byte(CHAR_START);
        for (k = 0; k < body_len; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_START || b == CHAR_END) b = b ^ 8'h40;
            if (with_ticks && $urandom_range(0, 9) == 0) send_ticks($urandom_range(1, 3));
            crc = telegram_tracker::crc_step(crc, b);
            send_byte(b);
        end
    endtask

    task automatic send_telegram(int body_len, csum_mode_t mode, bit with_ticks);
        logic [15:0] crc;
        logic [7:0]  b;
        int k, spoil, n_chars;
        fill_frame(body_len, with_ticks, crc);
        crc = telegram_tracker::crc_step(crc, CHAR_END);
        send_byte(CHAR_END);
        spoil = $urandom_range(0, 3);
        if (mode == CS_FLIP) crc[4*spoil +: 4] = crc[4*spoil +: 4] ^ 4'($urandom_range(1, 15));
        n_chars = (mode == CS_SHORT) ? $urandom_range(0, 3) : 4;
        for (k = 0; k < n_chars; k++) begin
            b = hex_digit(crc[15-4*k -: 4],
                          mode == CS_LOWER || (mode != CS_UPPER && $urandom_range(0, 1) == 1));
            if (k == spoil && mode == CS_BAD_CHAR) begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                       (b >= "a" && b <= "f"));
            end
            if (k == spoil && mode == CS_SLASH) b = CHAR_START;
            send_byte(b);
        end
        // run out the checksum window when it is short; a long window is only partly run
        if (mode == CS_SHORT) send_ticks(cur_crc + 1 > 40 ? 40 : cur_crc + 1);
    endtask

    // Hold the sender until every expected event is back and the pipe is empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timeouts(logic [CFG_W-1:0] rx, logic [CFG_W-1:0] crc);
        drain();
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_RX_TIMEOUT;
        cfg_data     <= rx;
        @(posedge aclk);
        cfg_index    <= REG_CRC_TIMEOUT;
        cfg_data     <= crc;
        @(posedge aclk);
        cfg_write_en <= 1'b0;
        tracker.set_timeouts(rx, crc);
        cur_rx  = rx;
        cur_crc = crc;
    endtask

    task automatic run_random(int budget);
        int unsigned start;
        int r, lim;
        csum_mode_t mode;
        start = counted;
        while (counted - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mode = CS_UPPER;
                    3:       mode = CS_LOWER;
                    4:       mode = CS_MIXED;
                    5:       mode = CS_FLIP;
                    6:       mode = CS_BAD_CHAR;
                    7:       mode = CS_SLASH;
                    8:       mode = CS_SHORT;
                    default: mode = CS_UPPER;
                endcase
                send_telegram(r < 5 ? $urandom_range(0, 60) : $urandom_range(0, 10), mode, 1'b1);
            end else if (r < 75) begin
                lim = 2 * cur_rx + 3 > 60 ? 60 : 2 * cur_rx + 3;
                send_ticks($urandom_range(1, lim));
            end else if (r < 88) begin
                // broken frame: abandon the body, then either tick toward a receive timeout or restart
                begin
                    logic [15:0] crc;
                    fill_frame($urandom_range(0, 5), 1'b0, crc);
                end
                if ($urandom_range(0, 1) == 1) send_ticks(cur_rx + 2 > 60 ? 60 : cur_rx + 2);
            end else begin
                // line noise; mostly dropped while idle
                counting = 1'b0;
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                counting = 1'b1;
            end
        end
    endtask

    initial begin
        logic [15:0] crc;
        int p;
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle ticks and bytes, upper, lower, bad-character and slash checksums, restart
        send_ticks(1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_telegram(0, CS_UPPER, 1'b0);
        send_telegram(0, CS_LOWER, 1'b0);
        send_telegram(0, CS_BAD_CHAR, 1'b0);
        send_byte(CHAR_START);
        send_byte(8'h78);
        send_telegram(1, CS_SLASH, 1'b0);

        // Full buffer: overflow on body byte and on end marker, end marker as
        // last slot, buffer full during checksum characters
        fill_frame(MAX_LEN - 3, 1'b0, crc);
        send_byte(8'h41);
        fill_frame(MAX_LEN - 3, 1'b0, crc);
        send_byte(CHAR_END);
        fill_frame(MAX_LEN - 4, 1'b0, crc);
        send_byte(CHAR_END);
        fill_frame(MAX_LEN - 6, 1'b0, crc);
        send_byte(CHAR_END);
        repeat (2) send_byte(hex_digit(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1));

        run_random(80);

        for (p = 1; p <= 7; p++) begin
            case (p)
                1:       set_timeouts(CFG_W'(1), CFG_W'(1));
                2:       set_timeouts(CFG_W'(0), CFG_W'(0));
                3:       set_timeouts(CFG_W'(30000), CFG_W'(30000));
                4:       set_timeouts(CFG_W'(32767), CFG_W'(32767));
                default: set_timeouts(CFG_W'($urandom_range(2, 12)),
                                      CFG_W'($urandom_range(1, 8)));
            endcase
            if (p == 3) begin
                // long windows: checksum timeout, then receive timeout
                send_byte(CHAR_START);
                send_byte(CHAR_END);
                send_ticks(30000);
                send_byte(CHAR_START);
                send_byte(8'h5A);
                send_ticks(30001);
            end
            if (p == 7) idle_on = 1'b0;
            run_random(60);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.due.size() != 0)
            tracker.report("events never delivered, count", 0, tracker.due.size());
        $display("Sent %0d beats over 8 timeout settings (zero, one, full scale, random)",
                 tracker.beats);
        $display("Events: %0d done, %0d crc timeout, %0d overflow, %0d rx timeout, %0d disconnect",
                 tracker.per_event[EV_DONE], tracker.per_event[EV_CRC_TIMEOUT],
                 tracker.per_event[EV_OVERFLOW], tracker.per_event[EV_RX_TIMEOUT],
                 tracker.per_event[EV_DISCONNECT]);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
